/* hdl/ssr_pkg.sv */
// Shared types and codes for the stack search-and-remove block.
// Used by ssr_ram, ssr_ctrl and stack_search_and_remove; no dependencies.
`default_nettype none

package ssr_pkg;

  localparam int ID_W         = 16;
  localparam int EV_W         = 3;
  localparam int CAPACITY_DEF = 8;

  // Request command
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DEPART = 1'b1;

  // Result event codes
  localparam logic [EV_W-1:0] EV_INSERTED = 3'd0;
  localparam logic [EV_W-1:0] EV_FULL     = 3'd1;
  localparam logic [EV_W-1:0] EV_STARTED  = 3'd2;
  localparam logic [EV_W-1:0] EV_MOVED    = 3'd3;
  localparam logic [EV_W-1:0] EV_DEPARTED = 3'd4;
  localparam logic [EV_W-1:0] EV_NOTFOUND = 3'd5;
  localparam logic [EV_W-1:0] EV_PUTBACK  = 3'd6;

  typedef struct packed {
    logic            cmd;
    logic [ID_W-1:0] plate;
  } ssr_in_t;

  typedef struct packed {
    logic [EV_W-1:0] event_res;
    logic [ID_W-1:0] ident;
    logic            is_last;
  } ssr_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PB_MISS,
    ST_PB_HIT
  } ssr_state_t;

endpackage

`default_nettype wire

/* hdl/ssr_ram.sv */
// Slot storage: one write port, one read port, registered read data.
// Depends on ssr_pkg for the identifier width.
`default_nettype none

module ssr_ram #(
  parameter int DEPTH = ssr_pkg::CAPACITY_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output      logic [ssr_pkg::ID_W-1:0] rd_data,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [ssr_pkg::ID_W-1:0] wr_data
);
  import ssr_pkg::*;

  logic [ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/ssr_ctrl.sv */
// Sequencer: fill count, walk index, slot RAM access and result register.
// Depends on ssr_pkg; drives the ssr_ram ports.
`default_nettype none

module ssr_ctrl #(
  parameter int CAPACITY = ssr_pkg::CAPACITY_DEF,
  localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire ssr_pkg::ssr_in_t         in_req,
  output      logic                     out_strobe,
  output      ssr_pkg::ssr_out_t        out_res,
  output      logic                     mem_rd_en,
  output      logic [AW-1:0]            mem_rd_addr,
  input  wire logic [ssr_pkg::ID_W-1:0] mem_rd_data,
  output      logic                     mem_wr_en,
  output      logic [AW-1:0]            mem_wr_addr,
  output      logic [ssr_pkg::ID_W-1:0] mem_wr_data
);
  import ssr_pkg::*;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  ssr_state_t      state_r, state_nxt;
  logic [CW-1:0]   fc_r, fc_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [ID_W-1:0] plate_r, plate_nxt;
  logic            out_vld_r, out_vld_nxt;
  ssr_out_t        out_r, out_nxt;

  logic            accept;
  logic            match;
  logic [CW-1:0]   fc_dec, idx_dec, idx_dec2, idx_inc;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign match      = (mem_rd_data == plate_r);
  assign fc_dec     = fc_r - ONE_C;
  assign idx_dec    = idx_r - ONE_C;
  assign idx_dec2   = idx_r - TWO_C;
  assign idx_inc    = idx_r + ONE_C;
  assign out_strobe = out_vld_r;
  assign out_res    = out_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_req.cmd == CMD_DEPART) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == '0) begin
          state_nxt = (fc_r == '0) ? ST_IDLE : ST_PB_MISS;
        end else if (match) begin
          state_nxt = (idx_r == fc_r) ? ST_IDLE : ST_PB_HIT;
        end
      end
      ST_PB_MISS: begin
        if (idx_inc == fc_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PB_HIT: begin
        if (idx_r == fc_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM access and results
  always_comb begin
    fc_nxt      = fc_r;
    idx_nxt     = idx_r;
    plate_nxt   = plate_r;
    out_vld_nxt = 1'b0;
    out_nxt     = out_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = fc_r[AW-1:0];
    mem_wr_data = in_req.plate;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          plate_nxt     = in_req.plate;
          out_vld_nxt   = 1'b1;
          out_nxt.ident = in_req.plate;
          if (in_req.cmd == CMD_ARRIVE) begin
            out_nxt.is_last = 1'b1;
            if (fc_r >= CAP_C) begin
              out_nxt.event_res = EV_FULL;
            end else begin
              out_nxt.event_res = EV_INSERTED;
              mem_wr_en         = 1'b1;
              fc_nxt            = fc_r + ONE_C;
            end
          end else begin
            // walk starts at the top entry
            out_nxt.event_res = EV_STARTED;
            out_nxt.is_last   = 1'b0;
            idx_nxt           = fc_r;
            mem_rd_en         = (fc_r != '0);
            mem_rd_addr       = fc_dec[AW-1:0];
          end
        end
      end
      ST_SCAN: begin
        out_vld_nxt = 1'b1;
        if (idx_r == '0) begin
          out_nxt.event_res = EV_NOTFOUND;
          out_nxt.ident     = plate_r;
          out_nxt.is_last   = (fc_r == '0);
          mem_rd_en         = (fc_r != '0);
          mem_rd_addr       = '0;
        end else if (match) begin
          // entries above the match drop one slot during put back
          out_nxt.event_res = EV_DEPARTED;
          out_nxt.ident     = plate_r;
          out_nxt.is_last   = (idx_r == fc_r);
          fc_nxt            = fc_dec;
          mem_rd_en         = (idx_r != fc_r);
          mem_rd_addr       = idx_r[AW-1:0];
        end else begin
          out_nxt.event_res = EV_MOVED;
          out_nxt.ident     = mem_rd_data;
          out_nxt.is_last   = 1'b0;
          idx_nxt           = idx_dec;
          mem_rd_en         = (idx_r > ONE_C);
          mem_rd_addr       = idx_dec2[AW-1:0];
        end
      end
      ST_PB_MISS: begin
        out_vld_nxt       = 1'b1;
        out_nxt.event_res = EV_PUTBACK;
        out_nxt.ident     = mem_rd_data;
        out_nxt.is_last   = (idx_inc == fc_r);
        idx_nxt           = idx_inc;
        mem_rd_en         = (idx_inc != fc_r);
        mem_rd_addr       = idx_inc[AW-1:0];
      end
      ST_PB_HIT: begin
        out_vld_nxt       = 1'b1;
        out_nxt.event_res = EV_PUTBACK;
        out_nxt.ident     = mem_rd_data;
        out_nxt.is_last   = (idx_r == fc_r);
        mem_wr_en         = 1'b1;
        mem_wr_addr       = idx_dec[AW-1:0];
        mem_wr_data       = mem_rd_data;
        idx_nxt           = idx_inc;
        mem_rd_en         = (idx_r != fc_r);
        mem_rd_addr       = idx_inc[AW-1:0];
      end
      default: begin
        out_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fc_r      <= '0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fc_r      <= fc_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plate_r <= plate_nxt;
    out_r   <= out_nxt;
  end

  // Fill count stays within capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CAP_C)
    else $error("fill count above capacity");

  // A final result always leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.is_last |-> state_r == ST_IDLE)
    else $error("final result while sequencer busy");

  // Returning to idle from a walk produces a final result
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE && state_nxt == ST_IDLE |=> out_vld_r && out_r.is_last)
    else $error("walk ended without final result");

  // Compaction never writes the slot being read in the same cycle
  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
    else $error("RAM read and write collide");

endmodule

`default_nettype wire

/* hdl/stack_search_and_remove.sv */
// Top level: bounded identifier stack with search and remove.
// Depends on ssr_pkg, ssr_ram and ssr_ctrl.
//
//  channel  | ports                        | flow
//  ---------+------------------------------+-----------------------------------
//  request  | start, busy, in_req          | taken when start=1 and busy=0
//  result   | out_strobe, out_res          | one strobe per result, no stall
//
// Results: an arrive request gives one result the next cycle and leaves busy low.
// A depart request on a stack of n entries gives one result per cycle, up to
// 2n+2, busy high until the final one issues. The single slot RAM read port,
// one entry per cycle, sets that figure.
// Reset: synchronous, active low; empties the stack, slot contents stay as is.
// The result side cannot stall: every strobe is a delivered result.
`default_nettype none

module stack_search_and_remove #(
  parameter int CAPACITY = ssr_pkg::CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire ssr_pkg::ssr_in_t  in_req,
  output      logic              out_strobe,
  output      ssr_pkg::ssr_out_t out_res
);
  import ssr_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Slot RAM port signals
  logic            mem_rd_en;
  logic [AW-1:0]   mem_rd_addr;
  logic [ID_W-1:0] mem_rd_data;
  logic            mem_wr_en;
  logic [AW-1:0]   mem_wr_addr;
  logic [ID_W-1:0] mem_wr_data;

  // Sequencer: pushes on arrive; on depart walks down from the top,
  // then walks back up issuing put-back results and closing the gap.
  ssr_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_strobe  (out_strobe),
    .out_res     (out_res),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // Slot storage, slot 0 at the bottom of the stack
  ssr_ram #(
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule

`default_nettype wire
